@@ src/cdec_pkg.sv @@
// Shared types and constants for the character escape decoder.
package cdec_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ESC   = 3'd1,
    ST_SHORT_UNI = 3'd2,
    ST_RANGE     = 3'd3,
    ST_EMPTY_HEX = 3'd4,
    ST_BARE      = 3'd5
  } status_t;

  localparam logic [1:0] WC_CHAR = 2'd0;
  localparam logic [1:0] WC_U8   = 2'd1;
  localparam logic [1:0] WC_16   = 2'd2;
  localparam logic [1:0] WC_32   = 2'd3;

  localparam logic [2:0] PFX_NONE = 3'd0;
  localparam logic [2:0] PFX_U8   = 3'd1;
  localparam logic [2:0] PFX_U    = 3'd2;
  localparam logic [2:0] PFX_L    = 3'd3;
  localparam logic [2:0] PFX_UU   = 3'd4;

  // One decoded item: a first result and an optional second one.
  typedef struct packed {
    logic        two;
    logic [31:0] val0;
    status_t     st0;
    logic [7:0]  val1;
    status_t     st1;
    logic [1:0]  cls;
  } op_t;

endpackage

@@ src/c_char_escape_decoder_unit.sv @@
// Each result is written to a queue slot as its byte is taken, then to the output register.
// Throughput: one byte per cycle in, one result per cycle out while popped; a byte that
// ends the digits of a hex or octal escape and is no backslash gives two results; the
// four-entry op queue absorbs the extra beat; input stalls only on a full queue, which pops
// drain. Reset is synchronous: escape state, queue and out_valid clear; empty goes high.
module c_char_escape_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte,
  input  logic        end_of_text,
  input  logic [2:0]  prefix,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] code_value,
  output logic [1:0]  width_class,
  output logic [2:0]  status,
  output logic        last
);

  logic          accept;
  logic          op_valid;
  cdec_pkg::op_t op;
  logic          q_avail;
  cdec_pkg::op_t q_head;
  logic          q_deq;
  logic          mid_record;

  assign accept = push && !full;

  cdec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_byte   (char_byte),
    .end_of_text (end_of_text),
    .prefix      (prefix),
    .op_valid    (op_valid),
    .op          (op)
  );

  cdec_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (op_valid),
    .wr_op (op),
    .full  (full),
    .avail (q_avail),
    .head  (q_head),
    .deq   (q_deq)
  );

  cdec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .avail       (q_avail),
    .deq         (q_deq),
    .pop         (pop),
    .code_value  (code_value),
    .width_class (width_class),
    .status      (status),
    .last        (last),
    .empty       (empty),
    .mid_record  (mid_record)
  );

  // Nothing is offered on the result side in the cycle after reset.
  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result offered straight after reset");

  // Every error beat carries a zero value.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != cdec_pkg::ST_OK) |-> (code_value == 32'd0))
    else $error("error beat with non-zero value");

  // While the second half of a record is pending, the beat shown is its non-final first half.
  a_first_half: assert property (@(posedge clk) disable iff (rst)
    mid_record |-> (!empty && !last))
    else $error("pending second half without a first half on the ports");

endmodule

@@ src/cdec_front.sv @@
// Front end: escape state machine that classifies each byte into result operations.
module cdec_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     char_byte,
  input  logic           end_of_text,
  input  logic [2:0]     prefix,
  output logic           op_valid,
  output cdec_pkg::op_t  op
);

  localparam logic [31:0] UNI_MAX  = 32'h0010FFFF;
  localparam logic [3:0]  OCT_MAX  = 4'd3;
  localparam logic [3:0]  HEX_MAX  = 4'd8;
  localparam logic [3:0]  U4_NEED  = 4'd4;
  localparam logic [3:0]  U8_NEED  = 4'd8;

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001,
    M_ESC  = 6'b000010,
    M_OCT  = 6'b000100,
    M_HEX  = 6'b001000,
    M_U4   = 6'b010000,
    M_U8   = 6'b100000
  } mode_t;

  mode_t       mode, mode_next;
  logic [3:0]  cnt, cnt_next;
  logic [31:0] acc, acc_next;

  logic [1:0]  cls;
  logic        is_hex, is_oct;
  logic [3:0]  hex_d;
  logic        fresh_esc, fresh_bare;
  logic [7:0]  fresh_val;
  cdec_pkg::status_t fresh_st;
  logic        simple_hit;
  logic [7:0]  simple_val;
  logic [3:0]  cnt_inc;
  logic [31:0] acc_oct, acc_hex;
  logic        emit0, emit1;

  always_comb begin
    case (prefix)
      cdec_pkg::PFX_U8:                  cls = cdec_pkg::WC_U8;
      cdec_pkg::PFX_U:                   cls = cdec_pkg::WC_16;
      cdec_pkg::PFX_L, cdec_pkg::PFX_UU: cls = cdec_pkg::WC_32;
      default:                           cls = cdec_pkg::WC_CHAR;
    endcase
  end

  always_comb begin
    is_hex = 1'b1;
    hex_d  = 4'd0;
    if (char_byte inside {["0":"9"]}) begin
      hex_d = char_byte[3:0];
    end else if (char_byte inside {["a":"f"], ["A":"F"]}) begin
      hex_d = char_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    simple_hit = 1'b1;
    simple_val = char_byte;
    case (char_byte)
      8'h27, 8'h22, 8'h3F, 8'h5C: simple_val = char_byte;
      "a":     simple_val = 8'd7;
      "b":     simple_val = 8'd8;
      "f":     simple_val = 8'd12;
      "n":     simple_val = 8'd10;
      "r":     simple_val = 8'd13;
      "t":     simple_val = 8'd9;
      "v":     simple_val = 8'd11;
      default: simple_hit = 1'b0;
    endcase
  end

  assign is_oct     = char_byte inside {["0":"7"]};
  assign fresh_esc  = (char_byte == 8'h5C);
  assign fresh_bare = (char_byte == 8'h27) || (char_byte == 8'h0A);
  assign fresh_st   = fresh_bare ? cdec_pkg::ST_BARE : cdec_pkg::ST_OK;
  assign fresh_val  = fresh_bare ? 8'd0 : char_byte;
  assign cnt_inc    = cnt + 4'd1;
  assign acc_oct    = {acc[28:0], char_byte[2:0]};
  assign acc_hex    = {acc[27:0], hex_d};

  always_comb begin
    mode_next = M_IDLE;
    cnt_next  = 4'd0;
    acc_next  = 32'd0;
    emit0     = 1'b0;
    emit1     = 1'b0;
    op.val0   = 32'd0;
    op.st0    = cdec_pkg::ST_OK;
    op.val1   = fresh_val;
    op.st1    = fresh_st;
    op.cls    = cls;
    case (mode)
      M_ESC: begin
        if (end_of_text) begin
          emit0  = 1'b1;
          op.st0 = cdec_pkg::ST_BAD_ESC;
        end else if (simple_hit) begin
          emit0   = 1'b1;
          op.val0 = {24'd0, simple_val};
        end else if (char_byte == "x") begin
          mode_next = M_HEX;
        end else if (char_byte == "u") begin
          mode_next = M_U4;
        end else if (char_byte == "U") begin
          mode_next = M_U8;
        end else if (is_oct) begin
          mode_next = M_OCT;
          cnt_next  = 4'd1;
          acc_next  = {29'd0, char_byte[2:0]};
        end else begin
          emit0  = 1'b1;
          op.st0 = cdec_pkg::ST_BAD_ESC;
        end
      end
      M_OCT: begin
        if (end_of_text) begin
          emit0   = 1'b1;
          op.val0 = acc;
        end else if (is_oct) begin
          if (cnt_inc >= OCT_MAX) begin
            emit0   = 1'b1;
            op.val0 = acc_oct;
          end else begin
            mode_next = M_OCT;
            cnt_next  = cnt_inc;
            acc_next  = acc_oct;
          end
        end else begin
          // The terminating byte starts a new literal character of its own.
          emit0   = 1'b1;
          op.val0 = acc;
          if (fresh_esc) begin
            mode_next = M_ESC;
          end else begin
            emit1 = 1'b1;
          end
        end
      end
      M_HEX: begin
        if (end_of_text || !is_hex) begin
          emit0 = 1'b1;
          if (cnt == 4'd0) begin
            op.st0 = cdec_pkg::ST_EMPTY_HEX;
          end else begin
            op.val0 = acc;
            if (!end_of_text) begin
              if (fresh_esc) begin
                mode_next = M_ESC;
              end else begin
                emit1 = 1'b1;
              end
            end
          end
        end else if (cnt_inc >= HEX_MAX) begin
          emit0   = 1'b1;
          op.val0 = acc_hex;
        end else begin
          mode_next = M_HEX;
          cnt_next  = cnt_inc;
          acc_next  = acc_hex;
        end
      end
      M_U4, M_U8: begin
        if (end_of_text || !is_hex) begin
          emit0  = 1'b1;
          op.st0 = cdec_pkg::ST_SHORT_UNI;
        end else if (cnt_inc >= ((mode == M_U4) ? U4_NEED : U8_NEED)) begin
          emit0 = 1'b1;
          if (acc_hex > UNI_MAX) begin
            op.st0 = cdec_pkg::ST_RANGE;
          end else begin
            op.val0 = acc_hex;
          end
        end else begin
          mode_next = mode;
          cnt_next  = cnt_inc;
          acc_next  = acc_hex;
        end
      end
      default: begin
        if (!end_of_text) begin
          if (fresh_esc) begin
            mode_next = M_ESC;
          end else begin
            emit0   = 1'b1;
            op.val0 = {24'd0, fresh_val};
            op.st0  = fresh_st;
          end
        end
      end
    endcase
    op.two = emit0 && emit1;
  end

  assign op_valid = accept && emit0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      cnt  <= 4'd0;
      acc  <= 32'd0;
    end else if (accept) begin
      mode <= mode_next;
      cnt  <= cnt_next;
      acc  <= acc_next;
    end
  end

endmodule

@@ src/cdec_queue.sv @@
// Short queue of decoded operations between the front end and the output stage.
module cdec_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cdec_pkg::op_t  wr_op,
  output logic           full,
  output logic           avail,
  output cdec_pkg::op_t  head,
  input  logic           deq
);

  localparam logic [cdec_pkg::QAW:0] FULL_COUNT = (cdec_pkg::QAW + 1)'(cdec_pkg::QDEPTH);

  cdec_pkg::op_t                slots [cdec_pkg::QDEPTH];
  logic [cdec_pkg::QAW-1:0]     wptr, rptr;
  logic [cdec_pkg::QAW:0]       count;
  logic                         do_push, do_deq;

  assign full    = (count == FULL_COUNT);
  assign avail   = (count != '0);
  assign head    = slots[rptr];
  assign do_push = push && !full;
  assign do_deq  = deq && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_deq) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_deq) begin
        count <= count + 1'b1;
      end else if (do_deq && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/cdec_back.sv @@
// Back end: splits each operation into result beats and holds them in the output register.
module cdec_back (
  input  logic           clk,
  input  logic           rst,
  input  cdec_pkg::op_t  head,
  input  logic           avail,
  output logic           deq,
  input  logic           pop,
  output logic [31:0]    code_value,
  output logic [1:0]     width_class,
  output logic [2:0]     status,
  output logic           last,
  output logic           empty,
  output logic           mid_record
);

  logic        out_valid;
  logic        sub;
  logic        load;
  logic [31:0] raw_val, masked_val;
  cdec_pkg::status_t sel_st;
  logic        sel_last;

  assign load = avail && (!out_valid || pop);

  always_comb begin
    if (sub) begin
      raw_val  = {24'd0, head.val1};
      sel_st   = head.st1;
      sel_last = 1'b1;
    end else begin
      raw_val  = head.val0;
      sel_st   = head.st0;
      sel_last = !head.two;
    end
    case (head.cls)
      cdec_pkg::WC_16: masked_val = raw_val & 32'h0000FFFF;
      cdec_pkg::WC_32: masked_val = raw_val;
      default:         masked_val = raw_val & 32'h000000FF;
    endcase
  end

  assign deq = load && (sub || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub       <= !sub && head.two;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_value  <= masked_val;
      width_class <= head.cls;
      status      <= sel_st;
      last        <= sel_last;
    end
  end

  assign empty      = !out_valid;
  assign mid_record = sub;

endmodule

@@ sim/cdec_checker.sv @@
// Result checker for the character escape decoder: predicts each beat and compares results.
`timescale 1ns / 1ps

module cdec_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  char_byte,
  input  logic        end_of_text,
  input  logic [2:0]  prefix,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] code_value,
  input  logic [1:0]  width_class,
  input  logic [2:0]  status,
  input  logic        last,
  output int          errors,
  output int          outstanding
);

  typedef enum logic [5:0] {
    ESC_NONE      = 6'b000001,
    ESC_BACKSLASH = 6'b000010,
    ESC_OCTAL     = 6'b000100,
    ESC_HEX       = 6'b001000,
    ESC_UNI4      = 6'b010000,
    ESC_UNI8      = 6'b100000
  } esc_mode_t;

  typedef struct packed {
    logic [31:0]       value;
    logic [1:0]        cls;
    cdec_pkg::status_t st;
    logic              last;
  } char_result_t;

  localparam logic [31:0] UNICODE_MAX = 32'h0010_FFFF;

  esc_mode_t    mode;
  logic [3:0]   ndigits;
  logic [31:0]  accum;
  char_result_t expected_chars[$];
  char_result_t beat_results[2];
  int           n_beat_results;

  function automatic int hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic void go_idle();
    mode    = ESC_NONE;
    ndigits = 4'd0;
    accum   = 32'd0;
  endfunction

  function automatic void add_result(logic [31:0] v, cdec_pkg::status_t st, logic [1:0] cls);
    char_result_t r;
    case (cls)
      cdec_pkg::WC_CHAR, cdec_pkg::WC_U8: r.value = v & 32'h0000_00FF;
      cdec_pkg::WC_16:                    r.value = v & 32'h0000_FFFF;
      default:                            r.value = v;
    endcase
    r.cls  = cls;
    r.st   = st;
    r.last = 1'b0;
    beat_results[n_beat_results] = r;
    n_beat_results++;
  endfunction

  // A byte that starts a new literal character.
  function automatic void start_char(logic [7:0] b, logic [1:0] cls);
    if (b == "\\") begin
      mode    = ESC_BACKSLASH;
      ndigits = 4'd0;
      accum   = 32'd0;
    end else if (b == 8'h27 || b == 8'h0A) begin
      add_result(32'd0, cdec_pkg::ST_BARE, cls);
    end else begin
      add_result({24'd0, b}, cdec_pkg::ST_OK, cls);
    end
  endfunction

  function automatic void escape_letter(logic [7:0] b, logic [1:0] cls);
    go_idle();
    case (b)
      8'h27, 8'h22, 8'h3F, 8'h5C: add_result({24'd0, b}, cdec_pkg::ST_OK, cls);
      "a": add_result(32'd7, cdec_pkg::ST_OK, cls);
      "b": add_result(32'd8, cdec_pkg::ST_OK, cls);
      "f": add_result(32'd12, cdec_pkg::ST_OK, cls);
      "n": add_result(32'd10, cdec_pkg::ST_OK, cls);
      "r": add_result(32'd13, cdec_pkg::ST_OK, cls);
      "t": add_result(32'd9, cdec_pkg::ST_OK, cls);
      "v": add_result(32'd11, cdec_pkg::ST_OK, cls);
      "x": mode = ESC_HEX;
      "u": mode = ESC_UNI4;
      "U": mode = ESC_UNI8;
      default: begin
        if (b >= "0" && b <= "7") begin
          mode    = ESC_OCTAL;
          ndigits = 4'd1;
          accum   = {29'd0, b[2:0]};
        end else begin
          add_result(32'd0, cdec_pkg::ST_BAD_ESC, cls);
        end
      end
    endcase
  endfunction

  function automatic void decode_beat(logic [7:0] b, logic eot, logic [2:0] pfx);
    logic [1:0]  cls;
    logic [31:0] acc;
    logic [31:0] nxt;
    logic [3:0]  need;
    int          h;
    case (pfx)
      cdec_pkg::PFX_U8:                  cls = cdec_pkg::WC_U8;
      cdec_pkg::PFX_U:                   cls = cdec_pkg::WC_16;
      cdec_pkg::PFX_L, cdec_pkg::PFX_UU: cls = cdec_pkg::WC_32;
      default:                           cls = cdec_pkg::WC_CHAR;
    endcase
    n_beat_results = 0;
    h   = hex_digit(b);
    acc = accum;
    case (mode)
      ESC_BACKSLASH: begin
        if (eot) begin
          go_idle();
          add_result(32'd0, cdec_pkg::ST_BAD_ESC, cls);
        end else begin
          escape_letter(b, cls);
        end
      end
      ESC_OCTAL: begin
        if (eot) begin
          go_idle();
          add_result(acc, cdec_pkg::ST_OK, cls);
        end else if (b >= "0" && b <= "7") begin
          nxt     = {acc[28:0], b[2:0]};
          accum   = nxt;
          ndigits = ndigits + 4'd1;
          if (ndigits >= 4'd3) begin
            go_idle();
            add_result(nxt, cdec_pkg::ST_OK, cls);
          end
        end else begin
          go_idle();
          add_result(acc, cdec_pkg::ST_OK, cls);
          start_char(b, cls);
        end
      end
      ESC_HEX: begin
        if (eot || h < 0) begin
          // The terminating byte is only decoded when some digits were seen.
          if (ndigits == 4'd0) begin
            go_idle();
            add_result(32'd0, cdec_pkg::ST_EMPTY_HEX, cls);
          end else begin
            go_idle();
            add_result(acc, cdec_pkg::ST_OK, cls);
            if (!eot) start_char(b, cls);
          end
        end else begin
          nxt     = {acc[27:0], 4'(h)};
          accum   = nxt;
          ndigits = ndigits + 4'd1;
          if (ndigits >= 4'd8) begin
            go_idle();
            add_result(nxt, cdec_pkg::ST_OK, cls);
          end
        end
      end
      ESC_UNI4, ESC_UNI8: begin
        need = (mode == ESC_UNI4) ? 4'd4 : 4'd8;
        if (eot || h < 0) begin
          go_idle();
          add_result(32'd0, cdec_pkg::ST_SHORT_UNI, cls);
        end else begin
          nxt     = {acc[27:0], 4'(h)};
          accum   = nxt;
          ndigits = ndigits + 4'd1;
          if (ndigits >= need) begin
            go_idle();
            if (nxt > UNICODE_MAX) add_result(32'd0, cdec_pkg::ST_RANGE, cls);
            else add_result(nxt, cdec_pkg::ST_OK, cls);
          end
        end
      end
      default: begin
        go_idle();
        if (!eot) start_char(b, cls);
      end
    endcase
    if (n_beat_results > 0) beat_results[n_beat_results - 1].last = 1'b1;
    for (int i = 0; i < n_beat_results; i++) expected_chars.push_back(beat_results[i]);
  endfunction

  always @(posedge clk) begin : watch
    char_result_t want;
    if (rst) begin
      go_idle();
      expected_chars.delete();
      errors = 0;
    end else begin
      if (push && !full) decode_beat(char_byte, end_of_text, prefix);
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $error("result with nothing expected: code_value %h status %0d", code_value, status);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (code_value !== want.value) begin
            $error("code_value: expected %h, got %h", want.value, code_value);
            errors++;
          end
          if (width_class !== want.cls) begin
            $error("width_class: expected %0d, got %0d", want.cls, width_class);
            errors++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
          end
        end
      end
    end
    outstanding <= expected_chars.size();
  end

endmodule

@@ sim/tb_top.sv @@
// Top of the escape decoder testbench: clock, reset, literal stimulus, result draining, verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int ITEM_TARGET = 1450;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_byte = 8'd0;
  logic        end_of_text = 1'b0;
  logic [2:0]  prefix = 3'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] code_value;
  logic [1:0]  width_class;
  logic [2:0]  status;
  logic        last;

  int   check_errors;
  int   outstanding;
  int   items_sent = 0;
  int   stall_cycles = 0;
  logic [2:0] lit_prefix = 3'd0;
  bit   send_steady = 1'b0;
  bit   pop_steady = 1'b0;

  c_char_escape_decoder_unit uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .char_byte(char_byte),
    .end_of_text(end_of_text), .prefix(prefix), .empty(empty), .pop(pop),
    .code_value(code_value), .width_class(width_class), .status(status), .last(last)
  );

  cdec_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .char_byte(char_byte),
    .end_of_text(end_of_text), .prefix(prefix), .empty(empty), .pop(pop),
    .code_value(code_value), .width_class(width_class), .status(status), .last(last),
    .errors(check_errors), .outstanding(outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Mostly back-to-back beats, with the odd long pause.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return 8'("0" + v);
    return ($urandom_range(0, 1) != 0) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eot, input logic [2:0] p);
    int gap;
    push        <= 1'b1;
    char_byte   <= b;
    end_of_text <= eot;
    prefix      <= p;
    do @(posedge clk); while (full);
    items_sent++;
    gap = pick_gap(send_steady);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Body byte of the current literal; now and then with a stray prefix.
  task automatic send_body(input logic [7:0] b);
    logic [2:0] p;
    p = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7)) : lit_prefix;
    send_item(b, 1'b0, p);
  endtask

  task automatic send_text(input string s, input logic [2:0] p);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0, p);
  endtask

  task automatic send_hex_digits(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) send_body(hex_char(int'(v[4*i +: 4])));
  endtask

  // One literal body: a handful of characters and escapes, then a random end-of-text byte.
  task automatic gen_literal();
    int          kind;
    int          n;
    logic [31:0] v;
    logic [7:0]  b;
    string       simple;
    simple = "'\"?\\abfnrtv";
    lit_prefix = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
    if ($urandom_range(0, 6) == 0) send_steady = !send_steady;
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        b = 8'($urandom);
        if (b == "\\") b = "A";
        if (kind < 3) b = ($urandom_range(0, 1) != 0) ? 8'h27 : 8'h0A;
        send_body(b);
      end else if (kind < 42) begin
        send_body("\\");
        send_body(simple[$urandom_range(0, simple.len() - 1)]);
      end else if (kind < 54) begin
        send_body("\\");
        repeat ($urandom_range(1, 3)) send_body(8'("0" + $urandom_range(0, 7)));
      end else if (kind < 68) begin
        send_body("\\");
        send_body("x");
        repeat ($urandom_range(0, 9)) send_body(hex_char($urandom_range(0, 15)));
      end else if (kind < 78) begin
        send_body("\\");
        send_body("u");
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
        send_hex_digits($urandom, n);
      end else if (kind < 88) begin
        send_body("\\");
        send_body("U");
        case ($urandom_range(0, 9))
          0:       v = 32'h0010_FFFF;
          1:       v = 32'h0011_0000;
          2, 3:    v = $urandom;
          default: v = $urandom_range(0, 32'h0010_FFFF);
        endcase
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
        send_hex_digits(v, n);
      end else if (kind < 94) begin
        send_body("\\");
        send_body(8'($urandom));
      end else begin
        send_item(8'($urandom), ($urandom_range(0, 3) == 0), 3'($urandom_range(0, 7)));
      end
    end
    send_item(8'($urandom), 1'b1, lit_prefix);
  endtask

  initial begin
    while (rst) @(posedge clk);
    send_item(8'h00, 1'b0, 3'd0);
    send_item(8'hFF, 1'b0, 3'd7);
    send_item(8'h27, 1'b0, 3'd1);
    send_item(8'h0A, 1'b0, 3'd2);
    send_text("\\?", 3'd3);
    send_text("\\q", 3'd4);
    send_text("\\xg", 3'd1);
    send_text("\\x4z", 3'd2);
    send_text("\\777", 3'd0);
    send_text("\\u1", 3'd3);
    send_item(8'h00, 1'b1, 3'd3);
    send_text("\\", 3'd0);
    send_item(8'h55, 1'b1, 3'd0);
    send_item(8'hAA, 1'b1, 3'd0);
    while (items_sent < ITEM_TARGET) gen_literal();
    push <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    if (check_errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side; twice it holds off for a long stretch so that the block fills and stalls.
  initial begin : drain
    int gap;
    int beats_taken;
    beats_taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (beats_taken == 60 || beats_taken == 500) gap = HOLD_CYCLES;
      else gap = pick_gap(pop_steady);
      if ($urandom_range(0, 49) == 0) pop_steady = !pop_steady;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      beats_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
